>>> design/amss_pkg.sv
package amss_pkg;

  localparam int unsigned PAIR_CHANNELS_DEF = 4;
  localparam int unsigned CHAN_W = 3;
  localparam int unsigned DATA_W = 24;
  localparam int unsigned SETTLE_W = 8;
  localparam logic [SETTLE_W-1:0] SETTLE_RST = 8'd8;
  localparam logic [SETTLE_W-1:0] SETTLE_MAX = 8'hff;
  localparam logic [CHAN_W-1:0] SCAN_LAST = 3'd7;

  typedef enum logic [1:0] {
    OP_SAMPLE   = 2'd0,
    OP_HOLD_ON  = 2'd1,
    OP_HOLD_OFF = 2'd2,
    OP_UNUSED   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    SEL_NONE    = 2'd0,
    SEL_CURRENT = 2'd1,
    SEL_VOLTAGE = 2'd2
  } sel_t;

  typedef enum logic [1:0] {
    KIND_CURRENT = 2'd0,
    KIND_VOLTAGE = 2'd1,
    KIND_BUILTIN = 2'd2
  } kind_t;

  typedef enum logic [8:0] {
    PH_IDLE   = 9'b000000001,
    PH_OPEN   = 9'b000000010,
    PH_SETTLE = 9'b000000100,
    PH_TRIG_I = 9'b000001000,
    PH_READ_I = 9'b000010000,
    PH_TRIG_V = 9'b000100000,
    PH_READ_V = 9'b001000000,
    PH_CLOSE  = 9'b010000000,
    PH_HOLD   = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [CHAN_W-1:0] ir_channel;
    logic [DATA_W-1:0] adc_data;
  } in_word_t;

  typedef struct packed {
    logic              mux_open;
    logic              mux_reset;
    logic [CHAN_W-1:0] mux_channel;
    logic              start_convert;
    logic [1:0]        trigger_select;
    logic [1:0]        read_select;
    logic              store_valid;
    logic [1:0]        store_kind;
    logic [1:0]        store_channel;
    logic [DATA_W-1:0] store_value;
  } out_word_t;

endpackage

>>> design/adc_mux_scan_sequencer_core.sv
// path: an accepted input word goes to the input register, and its result word goes to the
// result register and on out_; throughput: one word per cycle while out_stall is low, set by
// the single-pass phase logic between the input register and the result register
// reset: synchronous active-low rst_n; phase idle, channels and counters zero,
// settle_ticks back to 8
module adc_mux_scan_sequencer_core
  import amss_pkg::*;
#(
  parameter int unsigned PAIR_CHANNELS = PAIR_CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_word_t            in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output out_word_t           out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [SETTLE_W-1:0] cfg_data
);

  logic      adv;
  logic      item_valid;
  in_word_t  item_word;
  out_word_t res;

  assign cfg_ready = 1'b1;

  amss_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_word  (in_word),
    .in_stall (in_stall),
    .adv      (adv),
    .valid_r  (item_valid),
    .word_r   (item_word)
  );

  amss_seq #(
    .PAIR_CHANNELS (PAIR_CHANNELS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .fire      (adv),
    .word      (item_word),
    .res       (res)
  );

  amss_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (item_valid),
    .src_word  (res),
    .adv       (adv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

>>> design/amss_in_reg.sv
module amss_in_reg
  import amss_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_word_t in_word,
  output logic     in_stall,
  input  logic     adv,
  output logic     valid_r,
  output in_word_t word_r
);

  assign in_stall = valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      word_r <= in_word;
    end
  end

endmodule

>>> design/amss_seq.sv
module amss_seq
  import amss_pkg::*;
#(
  parameter int unsigned PAIR_CHANNELS = PAIR_CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic [SETTLE_W-1:0] cfg_data,
  input  logic                fire,
  input  in_word_t            word,
  output out_word_t           res
);

  phase_t              phase_r, phase_nxt;
  logic [SETTLE_W-1:0] settle_ticks_r;
  logic [SETTLE_W-1:0] settle_count_r, settle_count_nxt;
  logic [CHAN_W-1:0]   scan_channel_r, scan_channel_nxt;
  logic [CHAN_W-1:0]   hold_channel_r, hold_channel_nxt;
  logic [CHAN_W-1:0]   saved_channel_r, saved_channel_nxt;
  logic                hold_request_r, hold_request_nxt;
  logic [SETTLE_W-1:0] settle_inc;
  logic                is_pair;
  logic [1:0]          builtin_ch;

  assign is_pair    = {2'b00, scan_channel_r} < 5'(PAIR_CHANNELS);
  assign builtin_ch = scan_channel_r[1:0] - 2'(PAIR_CHANNELS);
  assign settle_inc = (settle_count_r < SETTLE_MAX) ? settle_count_r + 8'd1 : settle_count_r;

  always_comb begin
    phase_nxt         = phase_r;
    settle_count_nxt  = settle_count_r;
    scan_channel_nxt  = scan_channel_r;
    hold_channel_nxt  = hold_channel_r;
    saved_channel_nxt = saved_channel_r;
    hold_request_nxt  = hold_request_r;
    res               = '0;
    case (op_t'(word.op))
      OP_HOLD_ON: begin
        saved_channel_nxt = scan_channel_r;
        hold_channel_nxt  = word.ir_channel;
        hold_request_nxt  = 1'b1;
      end
      OP_HOLD_OFF: begin
        scan_channel_nxt = saved_channel_r;
        hold_request_nxt = 1'b0;
        phase_nxt        = PH_IDLE;
      end
      OP_SAMPLE: begin
        case (phase_r)
          PH_IDLE: begin
            phase_nxt        = PH_OPEN;
            settle_count_nxt = '0;
            scan_channel_nxt = '0;
          end
          PH_OPEN: begin
            res.mux_open     = 1'b1;
            settle_count_nxt = '0;
            if (hold_request_r) begin
              res.mux_reset    = 1'b1;
              scan_channel_nxt = hold_channel_r;
              phase_nxt        = PH_HOLD;
            end else begin
              phase_nxt = PH_SETTLE;
            end
            res.mux_channel = scan_channel_nxt;
          end
          PH_SETTLE: begin
            settle_count_nxt = settle_inc;
            if (settle_inc >= settle_ticks_r) begin
              res.start_convert = 1'b1;
              phase_nxt         = PH_TRIG_I;
              settle_count_nxt  = '0;
            end
          end
          PH_TRIG_I: begin
            res.trigger_select = SEL_CURRENT;
            phase_nxt          = PH_READ_I;
          end
          PH_READ_I: begin
            res.read_select = SEL_CURRENT;
            if (is_pair) begin
              res.store_valid   = 1'b1;
              res.store_kind    = KIND_CURRENT;
              res.store_channel = scan_channel_r[1:0];
              res.store_value   = word.adc_data;
            end
            phase_nxt = PH_TRIG_V;
          end
          PH_TRIG_V: begin
            res.trigger_select = SEL_VOLTAGE;
            phase_nxt          = PH_READ_V;
          end
          PH_READ_V: begin
            res.read_select = SEL_VOLTAGE;
            res.store_valid = 1'b1;
            res.store_value = word.adc_data;
            if (is_pair) begin
              res.store_kind    = KIND_VOLTAGE;
              res.store_channel = scan_channel_r[1:0];
            end else begin
              res.store_kind    = KIND_BUILTIN;
              res.store_channel = builtin_ch;
            end
            phase_nxt = PH_CLOSE;
          end
          PH_CLOSE: begin
            if (!hold_request_r) begin
              scan_channel_nxt = (scan_channel_r == SCAN_LAST) ? '0 : scan_channel_r + 3'd1;
            end
            phase_nxt = PH_OPEN;
          end
          PH_HOLD: begin
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_ticks_r <= SETTLE_RST;
    end else if (cfg_valid) begin
      settle_ticks_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      settle_count_r  <= '0;
      scan_channel_r  <= '0;
      hold_channel_r  <= '0;
      saved_channel_r <= '0;
      hold_request_r  <= 1'b0;
    end else if (fire) begin
      phase_r         <= phase_nxt;
      settle_count_r  <= settle_count_nxt;
      scan_channel_r  <= scan_channel_nxt;
      hold_channel_r  <= hold_channel_nxt;
      saved_channel_r <= saved_channel_nxt;
      hold_request_r  <= hold_request_nxt;
    end
  end

endmodule

>>> design/amss_out_reg.sv
module amss_out_reg
  import amss_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      src_valid,
  input  out_word_t src_word,
  output logic      adv,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic      valid_r;
  out_word_t word_r;

  assign adv       = src_valid && (!valid_r || !out_stall);
  assign out_valid = valid_r;
  assign out_word  = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      word_r <= src_word;
    end
  end

endmodule
